// ----- rtl/core/mhf_pkg.sv -----
package mhf_pkg;

  localparam int DEF_ANGLE_BITS        = 16;
  localparam int DEF_CORDIC_ITERATIONS = 16;
  localparam int ATAN_TABLE_LEN        = 24;
  localparam int GUARD_SHIFT           = 8;
  localparam int QUEUE_DEPTH           = 2;

  localparam logic [16:0] GAIN_RESET = 17'd6554;
  localparam logic [16:0] GAIN_ONE   = 17'd65536;

  typedef struct packed {
    logic              sample_ok;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic [15:0]        target_angle;
  } sample_t;

  typedef struct packed {
    logic [15:0]        heading;
    logic signed [15:0] heading_delta;
  } result_t;

  // Classified word handed from front to back.
  typedef struct packed {
    logic               ok;
    logic               rotate;     // nonzero vector with a good read
    logic               half_turn;  // vector was folded into the right half plane
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic [15:0]        target;
  } entry_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [31:0] atan_turn32(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h2000_0000;
      5'd1:    v = 32'h12E4_051E;
      5'd2:    v = 32'h09FB_385B;
      5'd3:    v = 32'h0511_11D4;
      5'd4:    v = 32'h028B_0D43;
      5'd5:    v = 32'h0145_D7E1;
      5'd6:    v = 32'h00A2_F61E;
      5'd7:    v = 32'h0051_7C55;
      5'd8:    v = 32'h0028_BE53;
      5'd9:    v = 32'h0014_5F2F;
      5'd10:   v = 32'h000A_2F98;
      5'd11:   v = 32'h0005_17CC;
      5'd12:   v = 32'h0002_8BE6;
      5'd13:   v = 32'h0001_45F3;
      5'd14:   v = 32'h0000_A2FA;
      5'd15:   v = 32'h0000_517D;
      5'd16:   v = 32'h0000_28BE;
      5'd17:   v = 32'h0000_145F;
      5'd18:   v = 32'h0000_0A30;
      5'd19:   v = 32'h0000_0518;
      5'd20:   v = 32'h0000_028C;
      5'd21:   v = 32'h0000_0146;
      5'd22:   v = 32'h0000_00A3;
      5'd23:   v = 32'h0000_0051;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/mhf_front.sv -----
module mhf_front (
  input  logic              sample_valid,
  input  mhf_pkg::sample_t  sample,
  input  logic              queue_full,
  output logic              sample_stall,
  output logic              push,
  output mhf_pkg::entry_t   push_entry
);
  import mhf_pkg::*;

  logic signed [16:0] x_ext;
  logic signed [16:0] y_ext;
  logic               neg;

  assign x_ext = 17'(sample.mag_x);
  assign y_ext = 17'(sample.mag_y);
  assign neg   = sample.mag_x[15];

  assign sample_stall = queue_full;
  assign push         = sample_valid && !queue_full;

  always_comb begin
    push_entry.ok        = sample.sample_ok;
    push_entry.rotate    = sample.sample_ok && ((sample.mag_x != '0) || (sample.mag_y != '0));
    push_entry.half_turn = neg;
    // fold the left half plane onto the right one
    push_entry.x         = neg ? -x_ext : x_ext;
    push_entry.y         = neg ? -y_ext : y_ext;
    push_entry.target    = sample.target_angle;
  end

endmodule

// ----- rtl/core/mhf_queue.sv -----
module mhf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mhf_pkg::entry_t  push_entry,
  input  logic             pop,
  output logic             full,
  output logic             nonempty,
  output mhf_pkg::entry_t  head
);
  import mhf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ----- rtl/core/mhf_back.sv -----
module mhf_back #(
  parameter int ANGLE_BITS        = mhf_pkg::DEF_ANGLE_BITS,
  parameter int CORDIC_ITERATIONS = mhf_pkg::DEF_CORDIC_ITERATIONS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             gain_valid,
  input  logic [16:0]      gain_data,
  output logic             gain_ready,
  input  logic             queue_nonempty,
  input  mhf_pkg::entry_t  head,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_stall,
  output mhf_pkg::result_t result
);
  import mhf_pkg::*;

  localparam int XW   = 28;
  localparam int IW   = $clog2(CORDIC_ITERATIONS);
  localparam int PW   = ANGLE_BITS + 18;
  localparam int AB   = ANGLE_BITS;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ROT    = 4'b0010,
    ST_SMOOTH = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t               state;
  logic [16:0]          gain;
  logic [AB-1:0]        filtered;
  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  logic [31:0]          z;
  logic [IW-1:0]        iter;
  logic                 ok;
  logic [AB-1:0]        target;
  logic signed [PW-1:0] prod;

  logic signed [XW-1:0] x_sh;
  logic signed [XW-1:0] y_sh;
  logic [31:0]          atan_val;
  logic [31:0]          z_round;
  logic [AB-1:0]        raw;
  logic signed [AB-1:0] diff;
  logic signed [PW-1:0] diff_ext;
  logic signed [PW-1:0] gain_ext;
  logic signed [PW:0]   round_sum;
  logic [AB-1:0]        step;
  logic [AB-1:0]        smoothed;
  logic [AB-1:0]        heading_ab;
  logic [AB-1:0]        delta_ab;
  logic [AB+15:0]       target_wide;
  logic [AB+15:0]       heading_wide;
  logic [AB+15:0]       delta_wide;
  logic                 out_free;

  assign gain_ready = 1'b1;
  assign pop        = (state == ST_IDLE) && queue_nonempty;
  assign out_free   = !result_valid || !result_stall;

  assign x_sh     = x >>> iter;
  assign y_sh     = y >>> iter;
  assign atan_val = atan_turn32(5'(iter));

  // round to AB bits: add half an LSB, keep the top bits
  assign z_round  = z + (32'd1 << (31 - AB));
  assign raw      = z_round[31 -: AB];
  assign diff     = signed'(raw - filtered);
  assign diff_ext = PW'(diff);
  assign gain_ext = signed'(PW'(gain));

  assign round_sum  = (PW + 1)'(prod) + (PW + 1)'(32768);
  assign step       = round_sum[AB+15:16];
  assign smoothed   = filtered + step;
  assign heading_ab = ok ? smoothed : '0;
  assign delta_ab   = target - heading_ab;

  assign target_wide  = {{AB{1'b0}}, head.target};
  assign heading_wide = {16'b0, heading_ab};
  assign delta_wide   = {{16{delta_ab[AB-1]}}, delta_ab};

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (gain_valid) begin
      gain <= (gain_data > GAIN_ONE) ? GAIN_ONE : gain_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      filtered     <= '0;
      result_valid <= 1'b0;
    end else begin
      // drop a taken word unless the next one replaces it
      if (result_valid && !result_stall && (state != ST_DONE)) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (queue_nonempty) begin
            state <= head.rotate ? ST_ROT : ST_SMOOTH;
          end
        end
        ST_ROT: begin
          if (iter == IW'(CORDIC_ITERATIONS - 1)) begin
            state <= ST_SMOOTH;
          end
        end
        ST_SMOOTH: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register can take the word
          if (out_free) begin
            result_valid <= 1'b1;
            if (ok) begin
              filtered <= smoothed;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (queue_nonempty) begin
          x      <= XW'(head.x) <<< GUARD_SHIFT;
          y      <= XW'(head.y) <<< GUARD_SHIFT;
          z      <= (head.rotate && head.half_turn) ? 32'h8000_0000 : 32'h0;
          iter   <= '0;
          ok     <= head.ok;
          target <= target_wide[AB-1:0];
        end
      end
      ST_ROT: begin
        if (y > 0) begin
          x <= x + y_sh;
          y <= y - x_sh;
          z <= z + atan_val;
        end else begin
          x <= x - y_sh;
          y <= y + x_sh;
          z <= z - atan_val;
        end
        iter <= iter + 1'b1;
      end
      ST_SMOOTH: begin
        prod <= diff_ext * gain_ext;
      end
      ST_DONE: begin
        if (out_free) begin
          result.heading       <= heading_wide[15:0];
          result.heading_delta <= signed'(delta_wide[15:0]);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/magnetometer_heading_filter.sv -----
// channel   direction  handshake                  word
// sample    in         sample_valid / sample_stall mhf_pkg::sample_t
// result    out        result_valid / result_stall mhf_pkg::result_t
// gain      in         gain_valid / gain_ready     17-bit smoothing gain, Q1.16
//
// In the back end a good nonzero sample runs ST_IDLE, ST_ROT, ST_SMOOTH and
// ST_DONE, with ST_ROT doing CORDIC_ITERATIONS steps on the one shared CORDIC
// micro-rotation stage; a failed read or a zero vector skips ST_ROT.
// The two-word queue lets the front accept samples while the back end works,
// and the output register lets the back end finish while the result is stalled.
// Reset clears the heading to 0 and loads the gain with 6554 (about 0.1).
module magnetometer_heading_filter #(
  parameter int ANGLE_BITS        = mhf_pkg::DEF_ANGLE_BITS,
  parameter int CORDIC_ITERATIONS = mhf_pkg::DEF_CORDIC_ITERATIONS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  mhf_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output mhf_pkg::result_t result,
  input  logic             gain_valid,
  output logic             gain_ready,
  input  logic [16:0]      gain_data
);
  import mhf_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   queue_full;
  logic   queue_nonempty;
  logic   pop;
  entry_t head;

  mhf_front u_front (
    .sample_valid (sample_valid),
    .sample       (sample),
    .queue_full   (queue_full),
    .sample_stall (sample_stall),
    .push         (push),
    .push_entry   (push_entry)
  );

  mhf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .nonempty   (queue_nonempty),
    .head       (head)
  );

  mhf_back #(
    .ANGLE_BITS        (ANGLE_BITS),
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .gain_valid     (gain_valid),
    .gain_data      (gain_data),
    .gain_ready     (gain_ready),
    .queue_nonempty (queue_nonempty),
    .head           (head),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result)
  );

endmodule
